@@ rtl/swmp_pkg.sv @@
// Package: shared constants, types and the reduction request type for the window product block.
`default_nettype none
package swmp_pkg;
  localparam int WindowMax = 1024;
  localparam int ValueBits = 31;
  localparam int AddrBits = $clog2(WindowMax);
  localparam int LenBits = 11;
  localparam int CfgIdxBits = 1;
  localparam logic [CfgIdxBits-1:0] CfgModulus = 1'd0;
  localparam logic [CfgIdxBits-1:0] CfgWindowLen = 1'd1;
  localparam logic [ValueBits-1:0] ModulusReset = 31'd1000000007;
  localparam logic [LenBits-1:0] WindowLenReset = 11'd1;
  typedef logic [ValueBits-1:0] val_t;
  typedef logic [AddrBits-1:0] addr_t;
  typedef struct packed {
    logic start;
    logic [2*ValueBits-1:0] a;
    val_t m;
  } mod_req_t;
endpackage
`default_nettype wire

@@ rtl/swmp_modred.sv @@
// Sequential reduction of a 62-bit value modulo a 31-bit modulus, one bit a cycle.
`default_nettype none
module swmp_modred (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire swmp_pkg::mod_req_t req_i,
  output logic                  busy_o,
  output swmp_pkg::val_t        res_o
);
  localparam int W = 2 * swmp_pkg::ValueBits;
  logic [W-1:0] a_q, a_d;
  logic [swmp_pkg::ValueBits:0] r_q, r_d;
  swmp_pkg::val_t m_q, m_d;
  logic [6:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic [swmp_pkg::ValueBits+1:0] sh;

  always_comb begin
    a_d = a_q; r_d = r_q; m_d = m_q; cnt_d = cnt_q; busy_d = busy_q;
    sh = {r_q, a_q[W-1]};
    if (req_i.start) begin
      a_d = req_i.a; r_d = '0; m_d = req_i.m; cnt_d = 7'(W); busy_d = 1'b1;
    end else if (busy_q) begin
      a_d = {a_q[W-2:0], 1'b0};
      if (sh >= {2'b00, m_q}) sh = sh - {2'b00, m_q};
      r_d = sh[swmp_pkg::ValueBits:0];
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    a_q <= a_d; r_q <= r_d; m_q <= m_d;
  end
  assign busy_o = busy_q;
  assign res_o = r_q[swmp_pkg::ValueBits-1:0];
endmodule
`default_nettype wire

@@ rtl/sliding_window_modular_product.sv @@
// Top level: sliding-window modular product over a stream of samples.
// Each accepted sample runs up to three serial reductions in turn (sample, prefix,
//   combine) before its result is loaded into the output register.
// One sample at a time; the next transfer follows the loaded result, and a block
//   end adds a suffix pass over sample memory before the next sample is taken.
// Reset: asynchronous, active low; clears control, counters and XOR, sets config to defaults; memories not.
`default_nettype none
module sliding_window_modular_product (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,  // [30:0] sample
  input  wire logic        s_tuser,  // new_stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0] m_tdata,       // [30:0] window_product, [61:31] xor_total
  output logic             m_tuser,  // window_full
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [30:0] cfg_data_i
);
  localparam int VB = swmp_pkg::ValueBits;
  localparam int AB = swmp_pkg::AddrBits;
  localparam int LB = swmp_pkg::LenBits;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001, S_RX = 8'b00000010, S_PRE = 8'b00000100,
    S_RD = 8'b00001000, S_CMB = 8'b00010000, S_OUT = 8'b00100000,
    S_SUF = 8'b01000000, S_SUFW = 8'b10000000
  } state_e;
  state_e st_q, st_d;

  swmp_pkg::val_t mod_q, m_eff;
  logic [LB-1:0] len_q, k_eff;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= swmp_pkg::ModulusReset; len_q <= swmp_pkg::WindowLenReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        swmp_pkg::CfgModulus:   mod_q <= cfg_data_i;
        swmp_pkg::CfgWindowLen: len_q <= cfg_data_i[LB-1:0];
        default: ;
      endcase
    end
  end
  assign m_eff = (mod_q == '0) ? VB'(1) : mod_q;
  always_comb begin
    k_eff = len_q;
    if (len_q == '0) k_eff = LB'(1);
    else if (len_q > LB'(swmp_pkg::WindowMax)) k_eff = LB'(swmp_pkg::WindowMax);
  end

  // memories: samples of current block and suffix products of previous block
  swmp_pkg::val_t samp_mem [swmp_pkg::WindowMax];
  swmp_pkg::val_t suf_mem [swmp_pkg::WindowMax];
  logic samp_we, suf_we;
  swmp_pkg::addr_t samp_wa, samp_ra, suf_wa, suf_ra;
  swmp_pkg::val_t samp_wd, suf_wd, samp_rd_q, suf_rd_q;
  always_ff @(posedge clk_i) begin
    if (samp_we) samp_mem[samp_wa] <= samp_wd;
    samp_rd_q <= samp_mem[samp_ra];
  end
  always_ff @(posedge clk_i) begin
    if (suf_we) suf_mem[suf_wa] <= suf_wd;
    suf_rd_q <= suf_mem[suf_ra];
  end

  swmp_pkg::mod_req_t req;
  logic red_busy;
  swmp_pkg::val_t red_res;
  swmp_modred u_red (.clk_i, .rst_ni, .req_i(req), .busy_o(red_busy), .res_o(red_res));

  swmp_pkg::val_t x_q, x_d, pre_q, pre_d, prod_q, prod_d, xor_q, xor_d, acc_q, acc_d;
  logic [LB-1:0] pos_q, pos_d, seen_q, seen_d, j_q, j_d;
  logic full_q, full_d, nst_q, nst_d;
  logic [LB-1:0] q_w, seen_w;
  logic last_w;

  // position and count after new_stream and config clamps
  always_comb begin
    q_w = nst_q ? '0 : pos_q;
    if (q_w >= k_eff) q_w = '0;
    seen_w = nst_q ? '0 : seen_q;
    if (seen_w > k_eff) seen_w = k_eff;
  end
  assign last_w = (q_w == k_eff - LB'(1));

  always_comb begin
    st_d = st_q; x_d = x_q; pre_d = pre_q; prod_d = prod_q; xor_d = xor_q;
    acc_d = acc_q; pos_d = pos_q; seen_d = seen_q; j_d = j_q; full_d = full_q;
    nst_d = nst_q;
    req = '0; req.m = m_eff;
    samp_we = 1'b0; samp_wa = q_w[AB-1:0]; samp_wd = x_q;
    samp_ra = j_q[AB-1:0];
    suf_we = 1'b0; suf_wa = j_q[AB-1:0]; suf_wd = red_res;
    suf_ra = AB'(q_w + LB'(1));
    s_tready = 1'b0;
    case (st_q)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          nst_d = s_tuser;
          req.start = 1'b1; req.a = {{VB{1'b0}}, s_tdata[VB-1:0]};
          st_d = S_RX;
        end
      end
      S_RX: if (!red_busy) begin
        x_d = red_res;
        if (q_w == '0) begin
          pre_d = red_res; st_d = S_RD;
        end else begin
          req.start = 1'b1; req.a = pre_q * red_res; st_d = S_PRE;
        end
      end
      S_PRE: if (!red_busy) begin
        pre_d = red_res; st_d = S_RD;
      end
      S_RD: begin
        // suffix read issued this cycle; store sample
        samp_we = 1'b1;
        if (nst_q) xor_d = '0;
        seen_d = (seen_w < k_eff) ? seen_w + LB'(1) : seen_w;
        full_d = (seen_d >= k_eff);
        pos_d = q_w; nst_d = 1'b0;
        prod_d = '0;
        if (full_d && last_w) prod_d = pre_q;
        st_d = (full_d && !last_w) ? S_CMB : S_OUT;
      end
      S_CMB: begin
        if (!red_busy && !(req.start)) begin
          if (prod_q == '0 && j_q != LB'(1)) begin
            req.start = 1'b1; req.a = suf_rd_q * pre_q; j_d = LB'(1);
          end else if (j_q == LB'(1)) begin
            prod_d = red_res; j_d = '0; st_d = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (full_q) xor_d = xor_q ^ prod_q;
        if (pos_q == k_eff - LB'(1)) begin
          pos_d = '0; acc_d = (m_eff == VB'(1)) ? '0 : VB'(1);
          j_d = k_eff; st_d = S_SUF;
        end else begin
          pos_d = pos_q + LB'(1); st_d = S_IDLE;
        end
      end
      S_SUF: begin
        // read sample j-1 for the suffix pass
        samp_ra = AB'(j_q - LB'(1));
        st_d = S_SUFW; j_d = j_q - LB'(1);
      end
      S_SUFW: begin
        if (!red_busy) begin
          if (!nst_q) begin
            req.start = 1'b1; req.a = acc_q * samp_rd_q; nst_d = 1'b1;
          end else begin
            acc_d = red_res; suf_we = 1'b1; nst_d = 1'b0;
            st_d = (j_q == '0) ? S_IDLE : S_SUF;
          end
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  // hold the result in an output register so a new sample can arrive while it waits
  logic ovalid_q;
  logic [VB-1:0] oprod_q, oxor_q;
  logic ofull_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) ovalid_q <= 1'b0;
      if (st_q == S_OUT) ovalid_q <= 1'b1;
    end
  end
  // load only once the pending transfer has gone
  always_ff @(posedge clk_i) begin
    if (st_q == S_OUT && !(ovalid_q && !m_tready)) begin
      oprod_q <= prod_q; ofull_q <= full_q; oxor_q <= xor_d;
    end
  end

  // stall the output state until the output register is free
  state_e st_g;
  assign st_g = (st_q == S_OUT && ovalid_q && !m_tready) ? S_OUT : st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; pre_q <= '0; pos_q <= '0; seen_q <= '0; xor_q <= '0;
      full_q <= 1'b0; nst_q <= 1'b0; j_q <= '0; prod_q <= '0;
    end else if (!(st_q == S_OUT && ovalid_q && !m_tready)) begin
      st_q <= st_g; pre_q <= pre_d; pos_q <= pos_d; seen_q <= seen_d; xor_q <= xor_d;
      full_q <= full_d; nst_q <= nst_d; j_q <= j_d; prod_q <= prod_d;
    end
  end
  always_ff @(posedge clk_i) begin
    x_q <= x_d; acc_q <= acc_d;
  end

  assign m_tvalid = ovalid_q;
  assign m_tdata = {2'b00, oxor_q, oprod_q};
  assign m_tuser = ofull_q;

  // accept input only when idle
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tready |-> st_q == S_IDLE) else $error("ready outside idle");
  // a pending result holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && !m_tready) |=> $stable(m_tdata)) else $error("result changed");
  // no full flag with an empty count
  a_full_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_OUT && full_q) |-> seen_q != '0) else $error("full with empty count");
endmodule
`default_nettype wire

@@ dv/tb.sv @@
// Testbench for the sliding-window modular product: stream stimulus and scoreboard check.
module tb;

  typedef struct packed {
    logic [30:0] product;
    logic        full;
    logic [30:0] xor_total;
  } window_result_t;

  // Tracks the window state and holds the expected products in order.
  class window_scoreboard;
    logic [30:0]      modulus;
    logic [10:0]      window_len;
    logic [30:0]      block_mem [swmp_pkg::WindowMax];
    logic [30:0]      suffix_mem[swmp_pkg::WindowMax];
    logic [30:0]      prefix;
    int unsigned      position;
    int unsigned      seen;
    logic [30:0]      xor_acc;
    window_result_t   expected_q[$];
    int               errors;

    function void reset_state();
      modulus    = swmp_pkg::ModulusReset;
      window_len = swmp_pkg::WindowLenReset;
      prefix     = '0;
      position   = 0;
      seen       = 0;
      xor_acc    = '0;
    endfunction

    function void write_reg(logic [0:0] idx, logic [30:0] data);
      if (idx == swmp_pkg::CfgModulus) modulus = data;
      else window_len = data[10:0];
    endfunction

    function logic [30:0] mul_mod(logic [30:0] a, logic [30:0] b, longint unsigned m);
      longint unsigned prod;
      prod = (longint'(a) % m) * (longint'(b) % m);
      return 31'(prod % m);
    endfunction

    function int unsigned eff_len();
      if (window_len == 0) return 1;
      if (window_len > swmp_pkg::WindowMax) return swmp_pkg::WindowMax;
      return window_len;
    endfunction

    // Advance the window by one accepted sample and queue its result.
    function void note_sample(logic [30:0] sample, logic new_stream);
      longint unsigned m;
      int unsigned     k, q;
      logic [30:0]     x, acc, prod;
      window_result_t  r;
      m = (modulus == 0) ? 1 : longint'(modulus);
      k = eff_len();
      x = 31'(longint'(sample) % m);
      prod = '0;
      if (new_stream) begin
        seen = 0; position = 0; xor_acc = '0;
      end
      if (position >= k) position = 0;
      if (seen > k) seen = k;
      q = position;
      prefix = (q == 0) ? x : mul_mod(prefix, x, m);
      block_mem[q] = x;
      if (seen < k) seen++;
      r.full = (seen >= k);
      if (r.full) begin
        prod = (q == k - 1) ? prefix : mul_mod(suffix_mem[q + 1], prefix, m);
        xor_acc ^= prod;
      end
      if (q == k - 1) begin
        acc = 31'(1 % m);
        for (int j = k - 1; j >= 0; j--) begin
          acc = mul_mod(acc, block_mem[j], m);
          suffix_mem[j] = acc;
        end
        position = 0;
      end else begin
        position = q + 1;
      end
      r.product   = prod;
      r.xor_total = xor_acc;
      expected_q.push_back(r);
    endfunction

    task report(string what, logic [30:0] got, logic [30:0] want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(logic [30:0] product, logic full, logic [30:0] xor_total);
      window_result_t e;
      if (expected_q.size() == 0) begin
        report("unexpected result", product, '0);
        return;
      end
      e = expected_q.pop_front();
      if (product !== e.product) report("window_product", product, e.product);
      if (full !== e.full) report("window_full", 31'(full), 31'(e.full));
      if (xor_total !== e.xor_total) report("xor_total", xor_total, e.xor_total);
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [30:0] sample
  logic        s_tuser = 1'b0; // new_stream
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;        // [30:0] window_product, [61:31] xor_total
  logic        m_tuser;        // window_full
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_idx_i = '0;
  logic [30:0] cfg_data_i = '0;

  window_scoreboard sb;
  int unsigned      cycle_count = 0;
  int unsigned      hold_cycles = 0;
  logic [30:0]      cur_modulus;

  sliding_window_modular_product u_dut (.*);

  always #4 clk_i = ~clk_i;

  // Count cycles and stop a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 4000000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Check every result transfer against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready)
      sb.check_result(m_tdata[30:0], m_tuser, m_tdata[61:31]);
  end

  // Receiver: a long hold-off when requested, rare long stalls, periodic always-ready spans, else short random stalls.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 499) == 0) begin
      hold_cycles <= $urandom_range(20, 80);
      m_tready <= 1'b0;
    end else if (cycle_count[11:9] == 3'd5) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  function int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  function logic [30:0] pick_sample();
    case ($urandom_range(0, 4))
      0: return 31'($urandom_range(0, 20));
      1: return (cur_modulus == 0) ? 31'($urandom) : cur_modulus - 31'($urandom_range(0, 2));
      2: return $urandom_range(0, 1) ? '1 : '0;
      default: return 31'($urandom);
    endcase
  endfunction

  // Offer one sample and hold it until the transfer happens.
  task send_sample(logic [30:0] sample, logic new_stream);
    int unsigned gap;
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, sample};
    s_tuser  <= new_stream;
    do @(posedge clk_i); while (!s_tready);
    sb.note_sample(sample, new_stream);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_tvalid <= 1'b0;
      s_tdata  <= {1'b0, 31'($urandom)};
      s_tuser  <= 1'($urandom_range(0, 1));
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Drop valid, let every expected result arrive and the suffix pass finish.
  task drain();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (sb.eff_len() * 70 + 400) @(posedge clk_i);
  endtask

  task write_reg(logic [0:0] idx, logic [30:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_data_i <= 31'($urandom);
    sb.write_reg(idx, data);
  endtask

  // Configure, restart the stream on the first sample, then random samples.
  task run_phase(logic [30:0] m, logic [10:0] k, int n, int ns_pct);
    write_reg(swmp_pkg::CfgModulus, m);
    write_reg(swmp_pkg::CfgWindowLen, 31'(k));
    cur_modulus = m;
    send_sample(pick_sample(), 1'b1);
    for (int i = 1; i < n; i++)
      send_sample(pick_sample(), ($urandom_range(0, 99) < ns_pct));
    drain();
  endtask

  initial begin
    sb = new();
    sb.errors = 0;
    sb.reset_state();
    cur_modulus = swmp_pkg::ModulusReset;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: single-sample window, samples at and above the modulus.
    send_sample('0, 1'b0);
    send_sample('1, 1'b0);
    send_sample(31'd1000000007, 1'b0);
    send_sample(31'd1000000008, 1'b0);
    send_sample(31'd999, 1'b1);
    for (int i = 0; i < 15; i++) send_sample(pick_sample(), 1'b0);
    drain();

    // Small window, small modulus; stream restart in mid block.
    write_reg(swmp_pkg::CfgModulus, 31'd7);
    write_reg(swmp_pkg::CfgWindowLen, 31'd3);
    cur_modulus = 31'd7;
    send_sample(31'd3, 1'b1);
    send_sample(31'd8, 1'b0);
    send_sample('1, 1'b0);
    send_sample(31'd6, 1'b0);
    send_sample(31'd0, 1'b0);
    send_sample(31'd5, 1'b1);
    send_sample(31'd2, 1'b0);
    send_sample(31'd4, 1'b0);
    send_sample(31'd14, 1'b0);
    for (int i = 0; i < 60; i++) send_sample(pick_sample(), ($urandom_range(0, 99) < 5));
    drain();

    // Largest window and modulus; the receiver holds off so the block backs up.
    hold_cycles = 3000;
    run_phase('1, 11'd1024, 1100, 0);
    run_phase(31'd2, 11'd1, 150, 5);
    run_phase(31'd1000000007, 11'd5, 200, 3);
    run_phase(31'd0, 11'd0, 40, 10);
    run_phase(31'd1, 11'd2047, 40, 0);
    run_phase(31'd12345, 11'd17, 150, 2);
    run_phase(31'd65521, 11'd64, 150, 1);

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/swmp_pkg.sv
rtl/swmp_modred.sv
rtl/sliding_window_modular_product.sv
dv/tb.sv
